// ----- sv/png16_pkg.sv -----
// ----------------------------------------------------------------------------
// png16_pkg
// Shared types, constants and byte helpers of the 16-bit gray PNG encoder.
// ----------------------------------------------------------------------------
package png16_pkg;

	localparam int MAX_DIM_DEF   = 16384;
	localparam int BLOCK_MAX_DEF = 65535;
	localparam int DIM_W         = 15;
	localparam int COL_W         = 14;
	localparam int TOTAL_W       = 30;
	localparam int IDX_W         = 6;
	localparam int MAX_RESULTS   = 51;

	localparam logic [DIM_W-1:0] CFG_RESET   = 15'd256;
	localparam logic [16:0]      ADLER_MOD   = 17'd65521;
	localparam logic [31:0]      CRC_POLY    = 32'hEDB88320;
	localparam logic [31:0]      CRC_INIT    = 32'hFFFFFFFF;

	// last position of the header, block header and trailer phases
	localparam logic [IDX_W-1:0] HDR_LAST  = 6'd42;
	localparam logic [IDX_W-1:0] BLK_LAST  = 6'd4;
	localparam logic [IDX_W-1:0] TAIL_LAST = 6'd19;

	// raw byte slots of one pixel
	localparam logic [1:0] SLOT_FILT = 2'd0;
	localparam logic [1:0] SLOT_HI   = 2'd1;
	localparam logic [1:0] SLOT_LO   = 2'd2;

	// register indexes on the config port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_HDR  = 5'b00010,
		PH_BLK  = 5'b00100,
		PH_RAW  = 5'b01000,
		PH_TAIL = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [TOTAL_W-1:0] total;
		logic [31:0]        idat_len;
	} dim_info_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       last;
		logic       fend;
	} seq_out_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = v[31:24];
			2'd1:    r = v[23:16];
			2'd2:    r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sig_byte(input logic [2:0] k);
		logic [7:0] r;
		case (k)
			3'd0:    r = 8'd137;
			3'd1:    r = 8'd80;
			3'd2:    r = 8'd78;
			3'd3:    r = 8'd71;
			3'd4:    r = 8'd13;
			3'd5:    r = 8'd10;
			3'd6:    r = 8'd26;
			default: r = 8'd10;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/png16_dimcalc.sv -----
// ----------------------------------------------------------------------------
// png16_dimcalc
// Latches image size, forms the raw byte count and the IDAT chunk length,
// counting stored blocks by a registered reciprocal multiplication.
// ----------------------------------------------------------------------------
module png16_dimcalc
	import png16_pkg::*;
#(
	parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIM_W-1:0] w_cl,
	input  logic [DIM_W-1:0] h_cl,
	output dim_info_t        dim
);

	// floor(x / BLOCK_MAX) == (x * RECIP) >> SHIFT for every x below 2^31
	localparam int          SHIFT      = 31 + $clog2(BLOCK_MAX);
	localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(BLOCK_MAX) - 64'd1)
		/ 64'(BLOCK_MAX);
	localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
	localparam logic [30:0] BMAX_M1    = 31'(BLOCK_MAX - 1);

	logic [DIM_W-1:0]   w_q, h_q;
	logic [TOTAL_W-1:0] total_q;
	logic [46:0]        prod_lo_q, prod_hi_q;
	logic [31:0]        blocks_q;
	logic [31:0]        idat_q;

	logic [30:0] round_up;
	logic [62:0] prod;

	// blocks = ceil(total / BLOCK_MAX)
	assign round_up = {1'b0, total_q} + BMAX_M1;
	assign prod     = {prod_hi_q, 16'd0} + {16'd0, prod_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= '0;
			h_q       <= '0;
			total_q   <= '0;
			prod_lo_q <= '0;
			prod_hi_q <= '0;
			blocks_q  <= '0;
			idat_q    <= '0;
		end else begin
			if (start) begin
				w_q     <= w_cl;
				h_q     <= h_cl;
				total_q <= TOTAL_W'(h_cl * {w_cl, 1'b1});
			end
			// products, then block count, then length settle long before the length is sent
			prod_lo_q <= {16'd0, round_up} * {31'd0, RECIP[15:0]};
			prod_hi_q <= {16'd0, round_up} * {31'd0, RECIP[31:16]};
			blocks_q  <= 32'(prod >> SHIFT);
			// six bytes of zlib header and checksum, five per stored block
			idat_q    <= 32'd6 + (blocks_q << 2) + blocks_q + {2'd0, total_q};
		end
	end

	assign dim.width    = w_q;
	assign dim.height   = h_q;
	assign dim.total    = total_q;
	assign dim.idat_len = idat_q;

endmodule

// ----- sv/png16_byteseq.sv -----
// ----------------------------------------------------------------------------
// png16_byteseq
// Byte sequencer: walks header, stored block headers, pixel bytes and trailer,
// updating CRC-32 over the chunk bytes and Adler-32 over the raw bytes.
// ----------------------------------------------------------------------------
module png16_byteseq
	import png16_pkg::*;
#(
	parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic [15:0] sample,
	input  logic        out_free,
	input  dim_info_t   dim,
	output logic        start,
	output seq_out_t    so
);

	localparam logic [15:0] BMAX = 16'(BLOCK_MAX);

	phase_t             phase_q, eph, phase_n;
	logic [IDX_W-1:0]   idx_q, eidx, idx_n;
	logic [1:0]         slot_q, eslot, slot_n;
	logic [5:0]         step_cnt_q;
	logic               hdr_done_q;
	logic [COL_W-1:0]   col_q;
	logic [15:0]        block_left_q, cur_q, adl_q, adh_q;
	logic [TOTAL_W-1:0] raw_left_q;
	logic [31:0]        crc_q;

	logic [15:0]        smp, len;
	logic [TOTAL_W-1:0] rl_dec;
	logic [15:0]        bl_dec;
	logic [7:0]         data;
	logic               into_crc, set_ones, done, last, emit;
	logic [31:0]        crc_inv, w32, h32, adler;
	logic [16:0]        lo_sum, lo_n, hi_sum, hi_n;
	logic [DIM_W-1:0]   col_inc;

	assign emit    = item_valid && out_free;
	assign smp     = (phase_q == PH_IDLE) ? sample : cur_q;
	assign len     = (raw_left_q < {14'd0, BMAX}) ? raw_left_q[15:0] : BMAX;
	assign rl_dec  = raw_left_q - TOTAL_W'(1);
	assign bl_dec  = block_left_q - 16'd1;
	assign crc_inv = ~crc_q;
	assign w32     = {17'd0, dim.width};
	assign h32     = {17'd0, dim.height};
	assign adler   = {adh_q, adl_q};
	assign col_inc = {1'b0, col_q} + DIM_W'(1);

	// where this byte sits; an idle sequencer opens a new step
	always_comb begin
		eph   = phase_q;
		eidx  = idx_q;
		eslot = slot_q;
		if (phase_q == PH_IDLE) begin
			eidx = '0;
			if (!hdr_done_q) begin
				eph   = PH_HDR;
				eslot = SLOT_FILT;
			end else begin
				eslot = (col_q == '0) ? SLOT_FILT : SLOT_HI;
				eph   = (block_left_q == 16'd0) ? PH_BLK : PH_RAW;
			end
		end
	end

	always_comb begin
		data     = 8'd0;
		into_crc = 1'b0;
		set_ones = 1'b0;
		unique case (eph)
			PH_HDR: begin
				into_crc = (eidx >= 6'd12 && eidx <= 6'd28) || (eidx >= 6'd37);
				set_ones = (eidx == 6'd11) || (eidx == 6'd32);
				case (eidx) inside
					[6'd0:6'd7]:   data = sig_byte(eidx[2:0]);
					6'd11:         data = 8'd13;
					6'd12, 6'd37:  data = 8'h49;
					6'd13:         data = 8'h48;
					6'd14, 6'd38:  data = 8'h44;
					6'd15:         data = 8'h52;
					[6'd16:6'd19]: data = be_byte(w32, eidx[1:0]);
					[6'd20:6'd23]: data = be_byte(h32, eidx[1:0]);
					6'd24:         data = 8'd16;
					6'd29:         data = crc_inv[31:24];
					6'd30:         data = crc_inv[23:16];
					6'd31:         data = crc_inv[15:8];
					6'd32:         data = crc_inv[7:0];
					6'd33:         data = dim.idat_len[31:24];
					6'd34:         data = dim.idat_len[23:16];
					6'd35:         data = dim.idat_len[15:8];
					6'd36:         data = dim.idat_len[7:0];
					6'd39:         data = 8'h41;
					6'd40:         data = 8'h54;
					6'd41:         data = 8'h78;
					6'd42:         data = 8'h01;
					default:       data = 8'd0;
				endcase
			end
			PH_BLK: begin
				into_crc = 1'b1;
				case (eidx)
					6'd0:    data = {7'd0, ({14'd0, len} == raw_left_q)};
					6'd1:    data = len[7:0];
					6'd2:    data = len[15:8];
					6'd3:    data = ~len[7:0];
					default: data = ~len[15:8];
				endcase
			end
			PH_RAW: begin
				into_crc = 1'b1;
				case (eslot)
					SLOT_FILT: data = 8'd0;
					SLOT_HI:   data = smp[15:8];
					default:   data = smp[7:0];
				endcase
			end
			PH_TAIL: begin
				into_crc = (eidx < 6'd4) || (eidx >= 6'd12 && eidx <= 6'd15);
				set_ones = (eidx == 6'd11);
				case (eidx) inside
					[6'd0:6'd3]:   data = be_byte(adler, eidx[1:0]);
					[6'd4:6'd7]:   data = be_byte(crc_inv, eidx[1:0]);
					6'd12:         data = 8'h49;
					6'd13:         data = 8'h45;
					6'd14:         data = 8'h4E;
					6'd15:         data = 8'h44;
					[6'd16:6'd19]: data = be_byte(crc_inv, eidx[1:0]);
					default:       data = 8'd0;
				endcase
			end
			PH_IDLE: data = 8'd0;
		endcase
	end

	// next position
	always_comb begin
		phase_n = eph;
		idx_n   = eidx + IDX_W'(1);
		slot_n  = eslot;
		done    = 1'b0;
		unique case (eph)
			PH_HDR: begin
				if (eidx == HDR_LAST) begin
					phase_n = PH_BLK;
					idx_n   = '0;
					slot_n  = SLOT_FILT;
				end
			end
			PH_BLK: begin
				if (eidx == BLK_LAST) begin
					phase_n = PH_RAW;
					idx_n   = '0;
				end
			end
			PH_RAW: begin
				idx_n = '0;
				if (eslot != SLOT_LO) begin
					slot_n  = eslot + 2'd1;
					phase_n = (bl_dec == 16'd0) ? PH_BLK : PH_RAW;
				end else if (rl_dec == '0) begin
					phase_n = PH_TAIL;
				end else begin
					phase_n = PH_IDLE;
					done    = 1'b1;
				end
			end
			PH_TAIL: begin
				if (eidx == TAIL_LAST) begin
					phase_n = PH_IDLE;
					done    = 1'b1;
				end
			end
			PH_IDLE: phase_n = PH_IDLE;
		endcase
	end

	// a step ends with its item, or when the per-item byte budget runs out
	assign last  = done || (step_cnt_q == 6'(MAX_RESULTS - 1));
	assign start = emit && (eph == PH_HDR) && (eidx == '0);

	// Adler-32 with a single conditional subtract per sum
	assign lo_sum = {1'b0, adl_q} + {9'd0, data};
	assign lo_n   = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
	assign hi_sum = {1'b0, adh_q} + lo_n;
	assign hi_n   = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			idx_q        <= '0;
			slot_q       <= SLOT_FILT;
			step_cnt_q   <= '0;
			hdr_done_q   <= 1'b0;
			col_q        <= '0;
			block_left_q <= '0;
			raw_left_q   <= '0;
			crc_q        <= CRC_INIT;
			adl_q        <= 16'd1;
			adh_q        <= 16'd0;
		end else if (emit) begin
			phase_q    <= phase_n;
			idx_q      <= idx_n;
			slot_q     <= slot_n;
			step_cnt_q <= last ? 6'd0 : step_cnt_q + 6'd1;
			if (into_crc) begin
				crc_q <= crc_byte(crc_q, data);
			end else if (set_ones) begin
				crc_q <= CRC_INIT;
			end
			if (eph == PH_HDR && eidx == '0) begin
				hdr_done_q   <= 1'b1;
				col_q        <= '0;
				block_left_q <= '0;
				adl_q        <= 16'd1;
				adh_q        <= 16'd0;
			end
			if (eph == PH_HDR && eidx == HDR_LAST) begin
				raw_left_q <= dim.total;
			end
			if (eph == PH_BLK && eidx == BLK_LAST) begin
				block_left_q <= len;
			end
			if (eph == PH_RAW) begin
				adl_q        <= lo_n[15:0];
				adh_q        <= hi_n[15:0];
				block_left_q <= bl_dec;
				raw_left_q   <= rl_dec;
				if (eslot == SLOT_LO) begin
					col_q <= (col_inc >= dim.width) ? '0 : col_inc[COL_W-1:0];
				end
			end
			if (eph == PH_TAIL && eidx == TAIL_LAST) begin
				hdr_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && phase_q == PH_IDLE) begin
			cur_q <= sample;
		end
	end

	assign so.emit = emit;
	assign so.data = data;
	assign so.last = last;
	assign so.fend = (eph == PH_TAIL) && (eidx == TAIL_LAST);

endmodule

// ----- sv/png_gray16_stored_encoder.sv -----
// ----------------------------------------------------------------------------
// png_gray16_stored_encoder
// Streams a complete 16-bit grayscale PNG file, one byte per output item,
// from gray samples in raster order, using stored deflate blocks.
// ----------------------------------------------------------------------------
// Each item waits in the input register; its bytes go out registered.
// Throughput: one output byte per cycle unless stalled; a pixel yields 2
//   bytes (3 at a row start, +5 at a stored block boundary, +43 for the
//   first pixel of an image and +20 for the last). An item yields at most
//   51 bytes; the rest follow on the next item, whose sample is then dropped.
// Reset: arst_n clears all control state; width and height return to 256.
// ----------------------------------------------------------------------------
module png_gray16_stored_encoder
	import png16_pkg::*;
#(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] sample,
	// byte channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        file_end,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0] cfg_w_q, cfg_h_q, w_cl, h_cl;
	logic             in_valid_q;
	logic [15:0]      in_sample_q;
	logic             out_valid_q, run_last_q, file_end_q;
	logic [7:0]       out_byte_q;
	logic             out_free, start;
	dim_info_t        dim;
	seq_out_t         so;

	// Config registers: written on the access phase, read back zero-extended.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {17'd0, cfg_h_q} : {17'd0, cfg_w_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_RESET;
			cfg_h_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WIDTH) begin
				cfg_w_q <= pwdata[DIM_W-1:0];
			end else begin
				cfg_h_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	// Zero counts as one, anything above the limit as the limit.
	assign w_cl = (cfg_w_q == '0) ? DIM_W'(1) : ((cfg_w_q > DIM_MAX) ? DIM_MAX : cfg_w_q);
	assign h_cl = (cfg_h_q == '0) ? DIM_W'(1) : ((cfg_h_q > DIM_MAX) ? DIM_MAX : cfg_h_q);

	// Input register: free again once the item's final byte goes out.
	assign in_ready = !in_valid_q || (so.emit && so.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (in_ready) begin
			in_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_sample_q <= sample;
		end
	end

	png16_dimcalc #(
		.BLOCK_MAX(BLOCK_MAX)
	) u_dimcalc (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.w_cl  (w_cl),
		.h_cl  (h_cl),
		.dim   (dim)
	);

	png16_byteseq #(
		.BLOCK_MAX(BLOCK_MAX)
	) u_byteseq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(in_valid_q),
		.sample    (in_sample_q),
		.out_free  (out_free),
		.dim       (dim),
		.start     (start),
		.so        (so)
	);

	// Output register: advance when it is empty or the consumer takes the held byte.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= so.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (so.emit) begin
			out_byte_q <= so.data;
			run_last_q <= so.last;
			file_end_q <= so.fend;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign file_end  = file_end_q;

endmodule

// ----- sv/png16_checker.sv -----
// ----------------------------------------------------------------------------
// png16_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module png16_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       file_end,
	input logic       pready
);

	// the file end byte always closes its item
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && file_end |-> run_last)
		else $error("file_end without run_last");

	// an idle input side stays ready
	a_ready_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("in_ready dropped with no item taken");

	// a stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled output changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind png_gray16_stored_encoder png16_checker u_png16_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_byte (out_byte),
	.run_last (run_last),
	.file_end (file_end),
	.pready   (pready)
);

// ----- bench/png_gray16_stored_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// png_gray16_stored_encoder_tb
// Streams gray samples into the PNG encoder and checks every output byte,
// its run_last and file_end flags, against a built-in byte-level predictor
// of the file format (signature, IHDR, stored zlib blocks, Adler, IEND).
// ----------------------------------------------------------------------------
module png_gray16_stored_encoder_tb;
	import png16_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fend;
	} file_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] sample;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        file_end;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	png_gray16_stored_encoder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.run_last(run_last), .file_end(file_end),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the encoder state
	logic [DIM_W-1:0] reg_width, reg_height;
	int unsigned      img_w, img_h;
	logic [31:0]      file_crc;
	int unsigned      sum_lo, sum_hi;
	int unsigned      col_pos, block_rem, raw_rem;
	bit               in_image;

	file_byte_t  staged_bytes[$];  // bytes produced but not yet handed out
	file_byte_t  expected_bytes[$];
	logic [15:0] sample_queue[$];

	int unsigned items_pushed, items_taken;
	int          mismatches;
	int          idle_mode;        // 0 none, 1 full, 2 sparse
	int          hold_req, hold_seen;

	initial begin
		clk = 1'b0;
	end
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
		logic [31:0] r;
		r = c ^ {24'd0, d};
		for (int k = 0; k < 8; k++)
			r = r[0] ? (32'hEDB88320 ^ (r >> 1)) : (r >> 1);
		return r;
	endfunction

	function automatic int unsigned fit_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
		return v;
	endfunction

	function automatic int idle_draw();
		case (idle_mode)
			1:       return $urandom_range(0, 15);
			2:       return ($urandom_range(0, 31) == 0) ? $urandom_range(0, 15) : 0;
			default: return 0;
		endcase
	endfunction

	task automatic stage(logic [7:0] d, bit into_crc, bit fe);
		file_byte_t fb;
		if (into_crc)
			file_crc = crc_step(file_crc, d);
		fb.data = d;
		fb.last = 1'b0;
		fb.fend = fe;
		staged_bytes.insert(staged_bytes.size(), fb);
	endtask

	task automatic stage_word(logic [31:0] v, bit into_crc);
		for (int k = 3; k >= 0; k--)
			stage(v[8*k +: 8], into_crc, 1'b0);
	endtask

	task automatic stage_tag(logic [31:0] tag);
		stage_word(tag, 1'b1);
	endtask

	// One zlib payload byte; open a stored block header when the last one ran out
	task automatic stage_payload(logic [7:0] d);
		int unsigned len;
		logic [15:0] nlen;
		if (block_rem == 0) begin
			len = (raw_rem < BLOCK_MAX_DEF) ? raw_rem : BLOCK_MAX_DEF;
			nlen = ~len[15:0];
			stage((len == raw_rem) ? 8'd1 : 8'd0, 1'b1, 1'b0);
			stage(len[7:0], 1'b1, 1'b0);
			stage(len[15:8], 1'b1, 1'b0);
			stage(nlen[7:0], 1'b1, 1'b0);
			stage(nlen[15:8], 1'b1, 1'b0);
			block_rem = len;
		end
		stage(d, 1'b1, 1'b0);
		sum_lo = sum_lo + d;
		if (sum_lo >= 65521) sum_lo -= 65521;
		sum_hi = sum_hi + sum_lo;
		if (sum_hi >= 65521) sum_hi -= 65521;
		if (block_rem > 0) block_rem--;
		if (raw_rem > 0) raw_rem--;
	endtask

	task automatic open_file();
		int unsigned total, blocks;
		logic [7:0] sig[8];
		sig = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
		img_w = fit_dim(reg_width);
		img_h = fit_dim(reg_height);
		total = img_h * (1 + 2 * img_w);
		blocks = (total + BLOCK_MAX_DEF - 1) / BLOCK_MAX_DEF;
		foreach (sig[k])
			stage(sig[k], 1'b0, 1'b0);
		stage_word(32'd13, 1'b0);
		file_crc = 32'hFFFFFFFF;
		stage_tag("IHDR");
		stage_word(img_w, 1'b1);
		stage_word(img_h, 1'b1);
		stage(8'd16, 1'b1, 1'b0);
		repeat (4) stage(8'd0, 1'b1, 1'b0);
		stage_word(~file_crc, 1'b0);
		stage_word(2 + 5 * blocks + total + 4, 1'b0);
		file_crc = 32'hFFFFFFFF;
		stage_tag("IDAT");
		stage(8'h78, 1'b1, 1'b0);
		stage(8'h01, 1'b1, 1'b0);
		sum_lo = 1;
		sum_hi = 0;
		col_pos = 0;
		block_rem = 0;
		raw_rem = total;
		in_image = 1'b1;
	endtask

	task automatic close_file();
		logic [31:0] c;
		stage_word({sum_hi[15:0], sum_lo[15:0]}, 1'b1);
		stage_word(~file_crc, 1'b0);
		stage_word(32'd0, 1'b0);
		file_crc = 32'hFFFFFFFF;
		stage_tag("IEND");
		c = ~file_crc;
		stage(c[31:24], 1'b0, 1'b0);
		stage(c[23:16], 1'b0, 1'b0);
		stage(c[15:8], 1'b0, 1'b0);
		stage(c[7:0], 1'b0, 1'b1);
		in_image = 1'b0;
	endtask

	// Work out the bytes of one accepted sample; leftovers from the previous
	// item go first and swallow the sample
	task automatic encode_sample(logic [15:0] s);
		file_byte_t fb;
		int n;
		if (staged_bytes.size() == 0) begin
			if (!in_image) open_file();
			if (col_pos == 0) stage_payload(8'd0);
			stage_payload(s[15:8]);
			stage_payload(s[7:0]);
			col_pos++;
			if (col_pos >= img_w) col_pos = 0;
			if (raw_rem == 0) close_file();
		end
		n = 0;
		while (staged_bytes.size() > 0 && n < MAX_RESULTS) begin
			fb = staged_bytes.pop_front();
			fb.last = (staged_bytes.size() == 0 || n == MAX_RESULTS - 1);
			expected_bytes.insert(expected_bytes.size(), fb);
			n++;
		end
	endtask

	// Sample driver: hold each item until taken, then idle a random gap
	int tx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				encode_sample(sample);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					in_valid <= 1'b1;
					sample   <= sample_queue.pop_front();
					tx_gap = idle_draw();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Byte monitor: compare each taken byte, then stall at random; a hold
	// request from the stimulus blocks the output for a long stretch
	int rx_gap, rx_hold;
	always @(posedge clk or negedge arst_n) begin
		file_byte_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap = 0;
			rx_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected byte %02h last=%0b end=%0b",
							out_byte, run_last, file_end);
				end else begin
					want = expected_bytes.pop_front();
					if (want.data !== out_byte || want.last !== run_last ||
							want.fend !== file_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("byte mismatch: want %02h/%0b/%0b got %02h/%0b/%0b",
								want.data, want.last, want.fend,
								out_byte, run_last, file_end);
					end
				end
				rx_gap = idle_draw();
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rx_hold = 400;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == 3'd4 * REG_WIDTH) reg_width = value[DIM_W-1:0];
		else if (addr == 3'd4 * REG_HEIGHT) reg_height = value[DIM_W-1:0];
	endtask

	task automatic set_size(int w, int h);
		write_reg(3'd4 * REG_WIDTH, w);
		write_reg(3'd4 * REG_HEIGHT, h);
	endtask

	task automatic queue_sample(logic [15:0] s);
		sample_queue.insert(sample_queue.size(), s);
		items_pushed++;
	endtask

	// Hold off until every item is taken and every byte has come out
	task automatic drain();
		do @(negedge clk);
		while (items_taken != items_pushed || expected_bytes.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	// Feed one whole image of random samples; a 1x1 image needs an extra
	// item to flush the bytes that did not fit
	task automatic send_image(int w, int h);
		int n;
		set_size(w, h);
		n = fit_dim(DIM_W'(w)) * fit_dim(DIM_W'(h));
		repeat (n) queue_sample(16'($urandom_range(0, 65535)));
		if (n == 1) queue_sample(16'($urandom_range(0, 65535)));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		reg_width = CFG_RESET;
		reg_height = CFG_RESET;
		in_image = 1'b0;
		file_crc = 32'hFFFFFFFF;
		sum_lo = 1;
		sum_hi = 0;
		col_pos = 0;
		block_rem = 0;
		raw_rem = 0;
		items_pushed = 0;
		items_taken = 0;
		mismatches = 0;
		idle_mode = 0;
		hold_req = 0;
		hold_seen = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// 1x1 image overflows one item; the second sample is swallowed
		set_size(1, 1);
		queue_sample(16'hFFFF);
		queue_sample(16'h0000);
		drain();
		// zero dimensions count as one
		set_size(0, 0);
		queue_sample(16'h0000);
		queue_sample(16'h5A5A);
		drain();
		// extremes of the sample, two rows
		set_size(3, 2);
		queue_sample(16'h0000);
		queue_sample(16'hFFFF);
		queue_sample(16'h8000);
		queue_sample(16'h7FFF);
		queue_sample(16'h0001);
		queue_sample(16'hFE00);
		drain();

		// long receiver hold while the sender keeps offering samples
		idle_mode = 0;
		set_size(8, 6);
		repeat (48) queue_sample(16'($urandom_range(0, 65535)));
		hold_req++;
		drain();

		// random small images, each with no, full or sparse idling at random
		while (items_pushed < 310) begin
			idle_mode = $urandom_range(0, 2);
			send_image($urandom_range(0, 8), $urandom_range(0, 6));
		end

		// oversized registers clamp; leave this image unfinished
		idle_mode = 1;
		set_size(15'h7FFF, 15'h7FFF);
		repeat (20) queue_sample(16'($urandom_range(0, 65535)));
		drain();

		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#6000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- png_gray16_stored_encoder.f -----
sv/png16_pkg.sv
sv/png16_dimcalc.sv
sv/png16_byteseq.sv
sv/png_gray16_stored_encoder.sv
sv/png16_checker.sv
bench/png_gray16_stored_encoder_tb.sv
